### hdl/snap_pkg.sv
// shared types and constants of the single-neuron adaptive pid core
package snap_pkg;

  localparam int DW        = 32;
  localparam int CW        = 18;
  localparam int XW        = 2 * CW;
  localparam int AW        = 36;
  localparam int BW        = CW + 1;
  localparam int PW        = AW + BW;
  localparam int ACCW      = AW + XW;
  localparam int Q_FRAC    = 16;
  localparam int RATE_FRAC = 28;
  localparam int SUMW      = ACCW - Q_FRAC;
  localparam int ADDR_W    = 5;

  localparam logic [DW-1:0] S32_MAX     = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] S32_MIN     = 32'h8000_0000;
  localparam logic [DW-1:0] OUT_MIN_RST = 32'hD8F0_0000;
  localparam logic [DW-1:0] OUT_MAX_RST = 32'h2710_0000;

  typedef enum logic [2:0] {
    REG_RATE_PROP,
    REG_RATE_INTEG,
    REG_RATE_DERIV,
    REG_INIT_ERR,
    REG_INIT_DIFF,
    REG_INIT_CURV,
    REG_OUT_MIN,
    REG_OUT_MAX
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERMS,
    ST_LO,
    ST_HI,
    ST_ADD,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    K_RATE,
    K_CTRL,
    K_LEARN
  } kind_t;

  typedef enum logic [1:0] {
    G_ERR,
    G_DIFF,
    G_CURV
  } grp_t;

  typedef struct packed {
    logic [DW-1:0] rate_prop;
    logic [DW-1:0] rate_integ;
    logic [DW-1:0] rate_deriv;
    logic [DW-1:0] out_min;
    logic [DW-1:0] out_max;
  } cfg_t;

  typedef struct packed {
    logic          ld_err;
    logic          ld_diff;
    logic          ld_curv;
    logic [DW-1:0] value;
  } wload_t;

endpackage

### hdl/snap_regs.sv
// apb register file with weight load strobes
module snap_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [snap_pkg::ADDR_W-1:0]  paddr,
  input  logic [snap_pkg::DW-1:0]      pwdata,
  output logic [snap_pkg::DW-1:0]      prdata,
  output logic                         pready,
  output snap_pkg::cfg_t               cfg,
  output snap_pkg::wload_t             wload
);

  logic                     wr;
  snap_pkg::reg_idx_t       idx;
  logic [snap_pkg::DW-1:0]  rate_prop;
  logic [snap_pkg::DW-1:0]  rate_integ;
  logic [snap_pkg::DW-1:0]  rate_deriv;
  logic [snap_pkg::DW-1:0]  init_err;
  logic [snap_pkg::DW-1:0]  init_diff;
  logic [snap_pkg::DW-1:0]  init_curv;
  logic [snap_pkg::DW-1:0]  out_min;
  logic [snap_pkg::DW-1:0]  out_max;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = snap_pkg::reg_idx_t'(paddr[snap_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_prop  <= '0;
      rate_integ <= '0;
      rate_deriv <= '0;
      init_err   <= '0;
      init_diff  <= '0;
      init_curv  <= '0;
      out_min    <= snap_pkg::OUT_MIN_RST;
      out_max    <= snap_pkg::OUT_MAX_RST;
    end else if (wr) begin
      case (idx)
        snap_pkg::REG_RATE_PROP:  rate_prop  <= pwdata;
        snap_pkg::REG_RATE_INTEG: rate_integ <= pwdata;
        snap_pkg::REG_RATE_DERIV: rate_deriv <= pwdata;
        snap_pkg::REG_INIT_ERR:   init_err   <= pwdata;
        snap_pkg::REG_INIT_DIFF:  init_diff  <= pwdata;
        snap_pkg::REG_INIT_CURV:  init_curv  <= pwdata;
        snap_pkg::REG_OUT_MIN:    out_min    <= pwdata;
        snap_pkg::REG_OUT_MAX:    out_max    <= pwdata;
        default:                  out_max    <= out_max;
      endcase
    end
  end

  always_comb begin
    case (idx)
      snap_pkg::REG_RATE_PROP:  prdata = rate_prop;
      snap_pkg::REG_RATE_INTEG: prdata = rate_integ;
      snap_pkg::REG_RATE_DERIV: prdata = rate_deriv;
      snap_pkg::REG_INIT_ERR:   prdata = init_err;
      snap_pkg::REG_INIT_DIFF:  prdata = init_diff;
      snap_pkg::REG_INIT_CURV:  prdata = init_curv;
      snap_pkg::REG_OUT_MIN:    prdata = out_min;
      snap_pkg::REG_OUT_MAX:    prdata = out_max;
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    cfg.rate_prop  = rate_prop;
    cfg.rate_integ = rate_integ;
    cfg.rate_deriv = rate_deriv;
    cfg.out_min    = out_min;
    cfg.out_max    = out_max;
    wload.ld_err   = wr && (idx == snap_pkg::REG_INIT_ERR);
    wload.ld_diff  = wr && (idx == snap_pkg::REG_INIT_DIFF);
    wload.ld_curv  = wr && (idx == snap_pkg::REG_INIT_CURV);
    wload.value    = pwdata;
  end

endmodule

### hdl/snap_mul.sv
// shared signed multiplier, one partial product per cycle, registered result
module snap_mul (
  input  logic                              clk,
  input  logic signed [snap_pkg::AW-1:0]    a,
  input  logic signed [snap_pkg::BW-1:0]    b,
  output logic signed [snap_pkg::PW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/snap_seq.sv
// sequencer and datapath: error history, terms, control sum, clamp and weight learning
module snap_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  snap_pkg::cfg_t                      cfg,
  input  snap_pkg::wload_t                    wload,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [snap_pkg::DW-1:0]             setpoint,
  input  logic [snap_pkg::DW-1:0]             measured,
  input  logic                                restart,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [snap_pkg::DW-1:0]             drive,
  output logic                                at_limit,
  output logic signed [snap_pkg::AW-1:0]      mul_a,
  output logic signed [snap_pkg::BW-1:0]      mul_b,
  input  logic signed [snap_pkg::PW-1:0]      mul_p
);

  localparam int DW   = snap_pkg::DW;
  localparam int AW   = snap_pkg::AW;
  localparam int XW   = snap_pkg::XW;
  localparam int CW   = snap_pkg::CW;
  localparam int PW   = snap_pkg::PW;
  localparam int ACCW = snap_pkg::ACCW;
  localparam int SUMW = snap_pkg::SUMW;

  snap_pkg::state_t   state;
  snap_pkg::state_t   state_next;
  snap_pkg::kind_t    kind;
  snap_pkg::grp_t     grp;
  snap_pkg::kind_t    cons_kind;
  snap_pkg::grp_t     cons_grp;
  logic               pend;

  logic [DW-1:0]      h0;
  logic [DW-1:0]      h1;
  logic [DW-1:0]      h2;
  logic [DW-1:0]      cv;
  logic [DW-1:0]      w_err;
  logic [DW-1:0]      w_diff;
  logic [DW-1:0]      w_curv;

  logic [XW-1:0]      bx1;
  logic [XW-1:0]      bx2;
  logic [XW-1:0]      bx3;
  logic [ACCW-1:0]    acc;
  logic [AW-1:0]      t;
  logic [SUMW-1:0]    sum;
  logic               lim;

  logic [DW:0]        err_d;
  logic [DW-1:0]      err_sat;
  logic [XW-1:0]      h0_x;
  logic [XW-1:0]      h1_x;
  logic [XW-1:0]      h2_x;
  logic [DW-1:0]      rate_sel;
  logic [DW-1:0]      w_sel;
  logic [XW-1:0]      x_sel;
  logic [AW-1:0]      op_a;
  logic [XW-1:0]      op_b;
  logic [ACCW-1:0]    p_ext;
  logic               consume_en;
  logic [DW-1:0]      w_cons;
  logic [SUMW:0]      lsum;
  logic [DW-1:0]      w_new;
  logic [SUMW-1:0]    lo_ext;
  logic [SUMW-1:0]    hi_ext;
  logic [DW-1:0]      clamp_val;
  logic               clamp_lim;
  logic               last_op;

  // error with saturation
  assign err_d   = {setpoint[DW-1], setpoint} - {measured[DW-1], measured};
  assign err_sat = (err_d[DW] != err_d[DW-1]) ?
                   (err_d[DW] ? snap_pkg::S32_MIN : snap_pkg::S32_MAX) : err_d[DW-1:0];

  assign h0_x = {{(XW-DW){h0[DW-1]}}, h0};
  assign h1_x = {{(XW-DW){h1[DW-1]}}, h1};
  assign h2_x = {{(XW-DW){h2[DW-1]}}, h2};

  assign last_op = (grp == snap_pkg::G_CURV) && (kind == snap_pkg::K_LEARN);

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      snap_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = snap_pkg::ST_TERMS;
      end
      snap_pkg::ST_TERMS: state_next = snap_pkg::ST_LO;
      snap_pkg::ST_LO:    state_next = snap_pkg::ST_HI;
      snap_pkg::ST_HI:    state_next = snap_pkg::ST_ADD;
      snap_pkg::ST_ADD:   state_next = last_op ? snap_pkg::ST_CLAMP : snap_pkg::ST_LO;
      snap_pkg::ST_CLAMP: state_next = snap_pkg::ST_OUT;
      snap_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = snap_pkg::ST_IDLE;
      end
      default: state_next = snap_pkg::ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (grp)
      snap_pkg::G_DIFF: begin
        rate_sel = cfg.rate_prop;
        w_sel    = w_diff;
        x_sel    = bx2;
      end
      snap_pkg::G_CURV: begin
        rate_sel = cfg.rate_deriv;
        w_sel    = w_curv;
        x_sel    = bx3;
      end
      default: begin
        rate_sel = cfg.rate_integ;
        w_sel    = w_err;
        x_sel    = bx1;
      end
    endcase
    case (kind)
      snap_pkg::K_RATE: begin
        op_a = {{(AW-DW){1'b0}}, rate_sel};
        op_b = bx1;
      end
      snap_pkg::K_CTRL: begin
        op_a = {{(AW-DW){w_sel[DW-1]}}, w_sel};
        op_b = x_sel;
      end
      default: begin
        op_a = t;
        op_b = x_sel;
      end
    endcase
    mul_a = op_a;
    if (state == snap_pkg::ST_HI) begin
      mul_b = {op_b[XW-1], op_b[XW-1:CW]};
    end else begin
      mul_b = {1'b0, op_b[CW-1:0]};
    end
  end

  assign p_ext = {{(ACCW-PW){mul_p[PW-1]}}, mul_p};

  // result of the finished partial-product pair
  assign consume_en = ((state == snap_pkg::ST_LO) && pend) || (state == snap_pkg::ST_CLAMP);

  always_comb begin
    case (cons_grp)
      snap_pkg::G_DIFF: w_cons = w_diff;
      snap_pkg::G_CURV: w_cons = w_curv;
      default:          w_cons = w_err;
    endcase
    lsum  = {{(SUMW+1-DW){w_cons[DW-1]}}, w_cons} + {acc[ACCW-1], acc[ACCW-1:snap_pkg::Q_FRAC]};
    if ((&lsum[SUMW:DW-1]) || !(|lsum[SUMW:DW-1])) begin
      w_new = lsum[DW-1:0];
    end else begin
      w_new = lsum[SUMW] ? snap_pkg::S32_MIN : snap_pkg::S32_MAX;
    end
  end

  // clamp, low limit tested first
  assign lo_ext = {{(SUMW-DW){cfg.out_min[DW-1]}}, cfg.out_min};
  assign hi_ext = {{(SUMW-DW){cfg.out_max[DW-1]}}, cfg.out_max};

  always_comb begin
    if ($signed(sum) < $signed(lo_ext)) begin
      clamp_val = cfg.out_min;
      clamp_lim = 1'b1;
    end else if ($signed(sum) > $signed(hi_ext)) begin
      clamp_val = cfg.out_max;
      clamp_lim = 1'b1;
    end else begin
      clamp_val = sum[DW-1:0];
      clamp_lim = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= snap_pkg::ST_IDLE;
      kind     <= snap_pkg::K_RATE;
      grp      <= snap_pkg::G_ERR;
      pend     <= 1'b0;
      h0       <= '0;
      h1       <= '0;
      h2       <= '0;
      cv       <= '0;
      w_err    <= '0;
      w_diff   <= '0;
      w_curv   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tready && (state != snap_pkg::ST_OUT)) m_tvalid <= 1'b0;
      case (state)
        snap_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            h0 <= restart ? '0 : h1;
            h1 <= restart ? '0 : h2;
            h2 <= err_sat;
            if (restart) cv <= '0;
          end
        end
        snap_pkg::ST_TERMS: begin
          kind <= snap_pkg::K_RATE;
          grp  <= snap_pkg::G_ERR;
          pend <= 1'b0;
        end
        snap_pkg::ST_ADD: begin
          pend <= 1'b1;
          case (kind)
            snap_pkg::K_RATE: kind <= snap_pkg::K_CTRL;
            snap_pkg::K_CTRL: kind <= snap_pkg::K_LEARN;
            default: begin
              kind <= snap_pkg::K_RATE;
              case (grp)
                snap_pkg::G_ERR:  grp <= snap_pkg::G_DIFF;
                snap_pkg::G_DIFF: grp <= snap_pkg::G_CURV;
                default:          grp <= snap_pkg::G_CURV;
              endcase
            end
          endcase
        end
        snap_pkg::ST_CLAMP: cv <= clamp_val;
        snap_pkg::ST_OUT: begin
          if (!m_tvalid || m_tready) m_tvalid <= 1'b1;
        end
        default: cv <= cv;
      endcase
      if (consume_en && (cons_kind == snap_pkg::K_LEARN)) begin
        case (cons_grp)
          snap_pkg::G_DIFF: w_diff <= w_new;
          snap_pkg::G_CURV: w_curv <= w_new;
          default:          w_err  <= w_new;
        endcase
      end
      if (wload.ld_err)  w_err  <= wload.value;
      if (wload.ld_diff) w_diff <= wload.value;
      if (wload.ld_curv) w_curv <= wload.value;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      snap_pkg::ST_TERMS: begin
        bx1 <= h2_x;
        bx2 <= h2_x - h1_x;
        bx3 <= h2_x - {h1_x[XW-2:0], 1'b0} + h0_x;
        sum <= {{(SUMW-DW){cv[DW-1]}}, cv};
      end
      snap_pkg::ST_HI: acc <= p_ext;
      snap_pkg::ST_ADD: begin
        acc       <= acc + {p_ext[ACCW-CW-1:0], {CW{1'b0}}};
        cons_kind <= kind;
        cons_grp  <= grp;
      end
      snap_pkg::ST_CLAMP: lim <= clamp_lim;
      snap_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          drive    <= cv;
          at_limit <= lim;
        end
      end
      default: acc <= acc;
    endcase
    if (consume_en) begin
      case (cons_kind)
        snap_pkg::K_RATE: t <= acc[AW+snap_pkg::RATE_FRAC-1:snap_pkg::RATE_FRAC];
        snap_pkg::K_CTRL: sum <= sum + acc[ACCW-1:snap_pkg::Q_FRAC];
        default:          t <= t;
      endcase
    end
  end

endmodule

### hdl/single_neuron_adaptive_pid_core.sv
// single-neuron adaptive pid core: items are processed one at a time, from accept to output beat
// nine products each pass through the lo, hi and add states on the one shared 36x19 multiplier (two partial
// products and an accumulate), plus a terms state, a clamp state and an out state that loads the output beat
// s_tready is high only while idle; the next item can be taken once the output beat is loaded and the core is idle
// synchronous reset clears history, control value and weights; writes to the init registers load the weights
module single_neuron_adaptive_pid_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [63:0]                        s_tdata,  // setpoint, measured
  input  logic                               s_tuser,  // restart
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,  // drive
  output logic                               m_tuser,  // at_limit
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [snap_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  snap_pkg::cfg_t                     cfg;
  snap_pkg::wload_t                   wload;
  logic signed [snap_pkg::AW-1:0]     mul_a;
  logic signed [snap_pkg::BW-1:0]     mul_b;
  logic signed [snap_pkg::PW-1:0]     mul_p;

  snap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .wload   (wload)
  );

  snap_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  snap_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .wload    (wload),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .setpoint (s_tdata[31:0]),
    .measured (s_tdata[63:32]),
    .restart  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .drive    (m_tdata),
    .at_limit (m_tuser),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p)
  );

endmodule
